>>> hw/rtl/tlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB package
// Shared sizes, types and codes for the fully associative TLB.
// ----------------------------------------------------------------------------
package tlb_pkg;

  localparam int TLB_ENTRIES = 8;
  localparam int PAGE_BITS   = 20;
  localparam int FRAME_BITS  = 20;
  localparam int COUNT_BITS  = 32;
  localparam int IDX_BITS    = $clog2(TLB_ENTRIES);

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } opcode_t;

  typedef enum logic {
    MODE_FIFO = 1'b0,
    MODE_LRU  = 1'b1
  } mode_t;

  // Entry write request.
  typedef struct packed {
    logic   en;
    idx_t   idx;
    page_t  page;
    frame_t frame;
  } entry_wr_t;

  // Result of the associative search.
  typedef struct packed {
    logic   hit;
    idx_t   hit_idx;
    frame_t frame;
    logic   has_free;
    idx_t   free_idx;
  } match_t;

  // Request to mark one entry as most recently used.
  typedef struct packed {
    logic en;
    idx_t idx;
  } touch_t;

endpackage

>>> hw/rtl/tlb_entries.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB entry array
// Page and frame storage with valid bits, parallel tag compare and a search
// for the lowest free entry.
// ----------------------------------------------------------------------------
module tlb_entries (
  input  logic               clk,
  input  logic               rst,
  input  tlb_pkg::entry_wr_t wr,
  input  tlb_pkg::page_t     lookup_page,
  output tlb_pkg::match_t    match
);
  import tlb_pkg::*;

  page_t                  entry_page  [TLB_ENTRIES];
  frame_t                 entry_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] entry_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr.en) begin
      entry_valid[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      entry_page[wr.idx]  <= wr.page;
      entry_frame[wr.idx] <= wr.frame;
    end
  end

  // Scanning from the top down leaves the lowest matching index in place.
  always_comb begin
    match = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && (entry_page[i] == lookup_page)) begin
        match.hit     = 1'b1;
        match.hit_idx = idx_t'(i);
        match.frame   = entry_frame[i];
      end
      if (!entry_valid[i]) begin
        match.has_free = 1'b1;
        match.free_idx = idx_t'(i);
      end
    end
  end

endmodule

>>> hw/rtl/tlb_rank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB recency ranks
// Keeps one recency rank per entry and picks the least recently used entry.
// ----------------------------------------------------------------------------
module tlb_rank (
  input  logic            clk,
  input  logic            rst,
  input  tlb_pkg::touch_t touch,
  output tlb_pkg::idx_t   lru_idx
);
  import tlb_pkg::*;

  idx_t rank [TLB_ENTRIES];
  idx_t old_rank;
  idx_t best_rank;

  assign old_rank = rank[touch.idx];

  // A touch moves the entry to the top rank and closes the gap it leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (touch.en) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (idx_t'(i) == touch.idx) begin
          rank[i] <= idx_t'(TLB_ENTRIES - 1);
        end else if (rank[i] > old_rank) begin
          rank[i] <= rank[i] - idx_t'(1);
        end
      end
    end
  end

  // Strict compare so that the lowest index wins among equal ranks.
  always_comb begin
    lru_idx   = '0;
    best_rank = rank[0];
    for (int i = 1; i < TLB_ENTRIES; i++) begin
      if (rank[i] < best_rank) begin
        lru_idx   = idx_t'(i);
        best_rank = rank[i];
      end
    end
  end

endmodule

>>> hw/rtl/tlb_fifo_lru_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fully associative TLB with FIFO or LRU replacement
// Eight-entry translation buffer with lookup, fill and saturating counters.
// ----------------------------------------------------------------------------
// The receiver cannot stall this block: every transaction accepted produces
// exactly one result, shown on the result ports for a single cycle while
// done is high, and it must be taken then. busy is always low, so a new
// transaction is taken at every clock edge at which start is high. A
// transaction accepted at one edge is captured in the input register; the
// next edge runs the tag compare, victim choice and state update and loads
// the result register, so done rises in the cycle after that, one result per
// cycle at full rate. The compare across all entries and the rank search for
// the LRU victim are the longest path. hit_total and lookup_total report the
// counts including the transaction they belong to. The mode register is
// written through mode_we and mode_wdata only while no transaction is in
// flight; the user must keep to this, as the block does not enforce it.
// ----------------------------------------------------------------------------
module tlb_fifo_lru_replacement (
  input  logic            clk,
  input  logic            rst,
  input  logic            mode_we,
  input  logic            mode_wdata,
  input  logic            start,
  output logic            busy,
  input  logic            opcode,
  input  tlb_pkg::page_t  page_number,
  input  tlb_pkg::frame_t frame_number,
  output logic            done,
  output logic            hit,
  output tlb_pkg::frame_t found_frame,
  output tlb_pkg::count_t hit_total,
  output tlb_pkg::count_t lookup_total
);
  import tlb_pkg::*;

  // Configuration register.
  mode_t mode;

  // Input register.
  logic    in_valid;
  opcode_t in_op;
  page_t   in_page;
  frame_t  in_frame;

  // Replacement and counter state.
  idx_t   fifo_ptr;
  idx_t   fifo_ptr_next;
  count_t hit_counter;
  count_t hit_counter_next;
  count_t lookup_counter;
  count_t lookup_counter_next;

  // Result register.
  logic   res_valid;
  logic   res_hit;
  logic   res_hit_next;
  frame_t res_frame;
  frame_t res_frame_next;

  entry_wr_t wr;
  match_t    match;
  touch_t    touch;
  idx_t      lru_idx;
  idx_t      victim;

  // The block keeps up with one transaction per cycle.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FIFO;
    end else if (mode_we) begin
      mode <= mode_t'(mode_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op    <= opcode_t'(opcode);
      in_page  <= page_number;
      in_frame <= frame_number;
    end
  end

  tlb_entries u_entries (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .lookup_page (in_page),
    .match       (match)
  );

  tlb_rank u_rank (
    .clk     (clk),
    .rst     (rst),
    .touch   (touch),
    .lru_idx (lru_idx)
  );

  // An LRU fill prefers the lowest free entry over the rank order.
  assign victim = match.has_free ? match.free_idx : lru_idx;

  always_comb begin
    wr                  = '0;
    touch               = '0;
    fifo_ptr_next       = fifo_ptr;
    hit_counter_next    = hit_counter;
    lookup_counter_next = lookup_counter;
    res_hit_next        = 1'b0;
    res_frame_next      = '0;
    if (in_valid) begin
      if (in_op == OP_LOOKUP) begin
        if (lookup_counter != '1) begin
          lookup_counter_next = lookup_counter + count_t'(1);
        end
        if (match.hit) begin
          res_hit_next   = 1'b1;
          res_frame_next = match.frame;
          if (hit_counter != '1) begin
            hit_counter_next = hit_counter + count_t'(1);
          end
          if (mode == MODE_LRU) begin
            touch.en  = 1'b1;
            touch.idx = match.hit_idx;
          end
        end
      end else if (mode == MODE_FIFO) begin
        // A page that is already present is left alone.
        if (!match.hit) begin
          wr.en    = 1'b1;
          wr.idx   = fifo_ptr;
          wr.page  = in_page;
          wr.frame = in_frame;
          if (fifo_ptr == idx_t'(TLB_ENTRIES - 1)) begin
            fifo_ptr_next = '0;
          end else begin
            fifo_ptr_next = fifo_ptr + idx_t'(1);
          end
        end
      end else begin
        wr.en     = 1'b1;
        wr.idx    = victim;
        wr.page   = in_page;
        wr.frame  = in_frame;
        touch.en  = 1'b1;
        touch.idx = victim;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_ptr       <= '0;
      hit_counter    <= '0;
      lookup_counter <= '0;
      res_valid      <= 1'b0;
    end else begin
      fifo_ptr       <= fifo_ptr_next;
      hit_counter    <= hit_counter_next;
      lookup_counter <= lookup_counter_next;
      res_valid      <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      res_hit   <= res_hit_next;
      res_frame <= res_frame_next;
    end
  end

  assign done         = res_valid;
  assign hit          = res_hit;
  assign found_frame  = res_frame;
  assign hit_total    = hit_counter;
  assign lookup_total = lookup_counter;

endmodule
